// ----- rtl/utf8d_pkg.sv -----
`timescale 1ns / 1ps
package utf8d_pkg;

   localparam int unsigned StoreDepth = 4;

   localparam logic [1:0] CLASS_ASCII   = 2'd0;
   localparam logic [1:0] CLASS_CONTROL = 2'd1;
   localparam logic [1:0] CLASS_UNICODE = 2'd2;
   localparam logic [1:0] CLASS_RAW     = 2'd3;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_ONE  = 3'd1;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   typedef logic [StoreDepth-1:0][7:0] pend_type;

   // what the head of the pending store yields
   typedef struct packed {
      logic        emit;
      logic [2:0]  len;
      logic [20:0] cp;
      logic [1:0]  cls;
   } dec_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic issue;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit;
      logic more;
      logic out_free;
   } sts_type;

   function automatic logic [2:0] lead_len(input logic [7:0] lead);
      logic [2:0] len;
      if (lead[7] == 1'b0) len = LEN_ONE;
      else if (lead[7:5] == 3'b110) len = LEN_TWO;
      else if (lead[7:4] == 4'b1110) len = LEN_THREE;
      else if (lead[7:3] == 5'b11110) len = LEN_FOUR;
      else len = LEN_NONE;
      return len;
   endfunction

   function automatic logic [1:0] class_of(input logic [20:0] cp);
      logic [1:0] cls;
      if (cp <= 21'h1F || (cp >= 21'h7F && cp <= 21'h9F)) cls = CLASS_CONTROL;
      else if (cp < 21'h7F) cls = CLASS_ASCII;
      else cls = CLASS_UNICODE;
      return cls;
   endfunction

   function automatic dec_type decide(input pend_type b, input logic [2:0] cnt,
                                      input logic fin);
      dec_type    d;
      logic [2:0] len;
      logic       ok;
      logic [20:0] cp;
      d   = '0;
      len = lead_len(b[0]);
      ok  = (len != LEN_NONE);
      for (int i = 1; i < StoreDepth; i++) begin
         if (3'(i) < len && 3'(i) < cnt && b[i][7:6] != 2'b10) ok = 1'b0;
      end
      unique case (len)
         LEN_TWO:   cp = {10'd0, b[0][4:0], b[1][5:0]};
         LEN_THREE: cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
         LEN_FOUR:  cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
         default:   cp = {14'd0, b[0][6:0]};
      endcase
      if (cnt == 3'd0) begin
         d.emit = 1'b0;
      end else if (ok && cnt >= len) begin
         d.emit = 1'b1;
         d.len  = len;
         d.cp   = cp;
         d.cls  = class_of(cp);
      end else if (!ok || fin) begin
         d.emit = 1'b1;
         d.len  = LEN_ONE;
         d.cp   = {13'd0, b[0]};
         d.cls  = CLASS_RAW;
      end
      return d;
   endfunction

   function automatic pend_type drop_head(input pend_type b, input logic [2:0] len);
      pend_type   r;
      logic [2:0] idx;
      r = b;
      for (int i = 0; i < StoreDepth; i++) begin
         idx = 3'(i) + len;
         if (idx < 3'(StoreDepth)) r[i] = b[idx[1:0]];
      end
      return r;
   endfunction

endpackage

// ----- rtl/utf8_decoder_with_raw_fallback_top.sv -----
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | req_in_byte[7:0], req_final_byte
// rsp     | out       | rsp_valid/rsp_ready | rsp_code_point[20:0], rsp_char_class[1:0],
//         |           |                     | rsp_byte_count[2:0], rsp_last_of_run
//
// a byte enters in idle; the scan loop then retires the results it causes (0 to 4), one
// pattern from the pending store per cycle while the output register is free, and goes
// back to idle when no further pattern is ready or when the byte causes none
// reset is synchronous, active high; it empties the pending store and the output register
// a result waits in the output register while the next byte is taken; a stalled rsp
// side holds the scan until the register frees
module utf8_decoder_with_raw_fallback_top
   import utf8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic [1:0]  rsp_char_class,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_last_of_run
);

   // command and status between controller and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: idle (takes a byte) and scan (retires patterns)
   utf8d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // pending store, pattern match and decode, output register
   utf8d_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_in_byte     (req_in_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_char_class  (rsp_char_class),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- rtl/utf8d_ctrl.sv -----
`timescale 1ns / 1ps
module utf8d_ctrl
   import utf8d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!sts.emit) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.issue = 1'b1;
               if (!sts.more) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ----- rtl/utf8d_dp.sv -----
`timescale 1ns / 1ps
module utf8d_dp
   import utf8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [7:0]  req_in_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic [1:0]  rsp_char_class,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_last_of_run
);

   pend_type    pend_ff, pend_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        fin_ff, fin_in;
   logic        out_valid_ff, out_valid_in;
   logic [20:0] cp_ff, cp_in;
   logic [1:0]  cls_ff, cls_in;
   logic [2:0]  bc_ff, bc_in;
   logic        last_ff, last_in;

   dec_type     dec_now, dec_next;
   pend_type    shifted;

   always_comb begin
      dec_now  = decide(pend_ff, cnt_ff, fin_ff);
      shifted  = drop_head(pend_ff, dec_now.len);
      dec_next = decide(shifted, cnt_ff - dec_now.len, fin_ff);
   end

   assign sts.emit     = dec_now.emit;
   assign sts.more     = dec_next.emit;
   assign sts.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      fin_in       = fin_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      cp_in        = cp_ff;
      cls_in       = cls_ff;
      bc_in        = bc_ff;
      last_in      = last_ff;
      if (cmd.load) begin
         // count is at most three between bytes
         pend_in[cnt_ff[1:0]] = req_in_byte;
         cnt_in               = cnt_ff + 3'd1;
         fin_in               = req_final_byte;
      end
      if (cmd.issue) begin
         pend_in      = shifted;
         cnt_in       = cnt_ff - dec_now.len;
         out_valid_in = 1'b1;
         cp_in        = dec_now.cp;
         cls_in       = dec_now.cls;
         bc_in        = dec_now.len;
         last_in      = !dec_next.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd0;
         fin_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         fin_ff       <= fin_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      cp_ff   <= cp_in;
      cls_ff  <= cls_in;
      bc_ff   <= bc_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_char_class  = cls_ff;
   assign rsp_byte_count  = bc_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ----- rtl/utf8d_check.sv -----
`timescale 1ns / 1ps
module utf8d_check
   import utf8d_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_in_byte,
   input logic        req_final_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [20:0] rsp_code_point,
   input logic [1:0]  rsp_char_class,
   input logic [2:0]  rsp_byte_count,
   input logic        rsp_last_of_run
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_point)
         && $stable(rsp_char_class) && $stable(rsp_byte_count)
         && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a raw byte is always one byte and fits in a byte
   a_raw_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_class == CLASS_RAW |->
         rsp_byte_count == LEN_ONE && rsp_code_point <= 21'hFF)
      else $error("bad raw result");

   // a single byte pattern decodes to seven bits
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_class != CLASS_RAW && rsp_byte_count == LEN_ONE |->
         rsp_code_point <= 21'h7F)
      else $error("bad single byte decode");

endmodule

bind utf8_decoder_with_raw_fallback_top utf8d_check u_check (.*);

// ----- verif/utf8_decoder_with_raw_fallback_top_tb.sv -----
`timescale 1ns / 1ps
module utf8_decoder_with_raw_fallback_top_tb;
   import utf8d_pkg::*;

   // one decoded point or raw byte as it leaves the block
   typedef struct packed {
      logic [20:0] cp;
      logic [1:0]  cls;
      logic [2:0]  cnt;
      logic        last;
   } utf8_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_final_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [20:0] rsp_code_point;
   logic [1:0]  rsp_char_class;
   logic [2:0]  rsp_byte_count;
   logic        rsp_last_of_run;

   // decoder state as the predictor sees it
   logic [7:0]      held_bytes [StoreDepth];
   int unsigned     held_count;
   utf8_result_type expected_points [$];

   // idle rates in percent, changed per phase
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned error_count;

   utf8_decoder_with_raw_fallback_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_char_class  (rsp_char_class),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic note_error(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // shift the held bytes down by n entries
   task automatic drop_held(input int unsigned n);
      repeat (n) begin
         for (int i = 0; i < StoreDepth - 1; i++) held_bytes[i] = held_bytes[i + 1];
         held_count--;
      end
   endtask

   // append one byte to the held store and decode everything the head allows
   task automatic decode_held_bytes(input logic [7:0] b, input logic fin);
      utf8_result_type run [StoreDepth];
      int unsigned     n;
      int unsigned     avail;
      logic [2:0]      len;
      logic [20:0]     cp;
      logic [1:0]      cls;
      logic            ok;
      logic            waiting;
      n = 0;
      waiting = 1'b0;
      held_bytes[held_count] = b;
      held_count++;
      while (held_count > 0 && !waiting) begin
         casez (held_bytes[0])
            8'b0???????: len = LEN_ONE;
            8'b110?????: len = LEN_TWO;
            8'b1110????: len = LEN_THREE;
            8'b11110???: len = LEN_FOUR;
            default:     len = LEN_NONE;
         endcase
         ok = (len != LEN_NONE);
         avail = (held_count < len) ? held_count : len;
         // every byte after the lead that is already here must be a continuation
         for (int i = 1; i < avail; i++) begin
            if (held_bytes[i][7:6] != 2'b10) ok = 1'b0;
         end
         if (ok && held_count >= len) begin
            case (len)
               LEN_TWO:   cp = {10'd0, held_bytes[0][4:0], held_bytes[1][5:0]};
               LEN_THREE: cp = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0],
                                held_bytes[2][5:0]};
               LEN_FOUR:  cp = {held_bytes[0][2:0], held_bytes[1][5:0],
                                held_bytes[2][5:0], held_bytes[3][5:0]};
               default:   cp = {14'd0, held_bytes[0][6:0]};
            endcase
            if (cp <= 21'h1F || (cp >= 21'h7F && cp <= 21'h9F)) cls = CLASS_CONTROL;
            else if (cp < 21'h7F) cls = CLASS_ASCII;
            else cls = CLASS_UNICODE;
            run[n] = '{cp, cls, len, 1'b0};
            n++;
            drop_held(len);
         end else if (!ok || fin) begin
            // bad lead, broken continuation or flush at end of stream
            run[n] = '{{13'd0, held_bytes[0]}, CLASS_RAW, LEN_ONE, 1'b0};
            n++;
            drop_held(1);
         end else begin
            waiting = 1'b1;
         end
      end
      if (n > 0) run[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_points = {expected_points, run[i]};
   endtask

   // one byte transfer on req; payload set at the falling edge, held until taken
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (!req_ready);
      decode_held_bytes(b, fin);
   endtask

   // drop valid and wait until every predicted result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] cont_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   // random text: mostly whole characters, some broken or cut short, some noise
   task automatic send_random_text(input int unsigned n_bytes);
      int unsigned sent;
      int unsigned kind;
      int unsigned len;
      int unsigned cut;
      logic [7:0]  lead;
      sent = 0;
      while (sent < n_bytes) begin
         kind = $urandom_range(0, 99);
         len  = (kind < 65) ? $urandom_range(1, 4) : $urandom_range(2, 4);
         case (len)
            LEN_ONE:   lead = {1'b0, 7'($urandom)};
            LEN_TWO:   lead = {3'b110, 5'($urandom)};
            LEN_THREE: lead = {4'b1110, 4'($urandom)};
            default:   lead = {5'b11110, 3'($urandom)};
         endcase
         cut = $urandom_range(1, len - 1);
         if (kind < 65) begin
            // well-formed character, now and then closing the stream
            send_byte(lead, len == 1 && $urandom_range(0, 15) == 0);
            for (int k = 1; k < len; k++)
               send_byte(cont_byte(), k == len - 1 && $urandom_range(0, 15) == 0);
            sent += len;
         end else if (kind < 80) begin
            // sequence interrupted by a byte that is not a continuation
            send_byte(lead, 1'b0);
            for (int k = 1; k < cut; k++) send_byte(cont_byte(), 1'b0);
            case ($urandom_range(0, 2))
               0:       send_byte({2'b00, 6'($urandom)}, 1'b0);
               1:       send_byte({2'b01, 6'($urandom)}, 1'b0);
               default: send_byte({2'b11, 6'($urandom)}, 1'b0);
            endcase
            sent += cut + 1;
         end else if (kind < 85) begin
            // stream ends in the middle of a sequence
            send_byte(lead, cut == 1);
            for (int k = 1; k < cut; k++) send_byte(cont_byte(), k == cut - 1);
            sent += cut;
         end else begin
            send_byte(8'($urandom), $urandom_range(0, 15) == 0);
            sent++;
         end
      end
      wait_for_results();
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // single bytes at the class edges
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h41, 1'b0);
      // two-byte: last control point and largest two-byte point
      send_byte(8'hC2, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // largest three-byte point
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // all ones in every payload bit of a four-byte pattern
      send_byte(8'hF7, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // invalid lead bytes go out raw right away
      send_byte(8'h80, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'hFF, 1'b0);
      // broken continuation after three held bytes: four results from one byte
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h41, 1'b0);
      // end of stream with an incomplete pattern flushes it raw
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90, 1'b1);
      // end of stream on an empty store
      send_byte(8'h7E, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_full_rate();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_random_text(45);
   endtask

   task automatic test_random_sender_idle();
      send_idle_pct = 85;
      rsp_stall_pct = 0;
      send_random_text(45);
   endtask

   task automatic test_random_receiver_stall();
      send_idle_pct = 0;
      rsp_stall_pct = 85;
      send_random_text(45);
   endtask

   task automatic test_random_both_idle();
      send_idle_pct = 19;
      rsp_stall_pct = 19;
      send_random_text(50);
   endtask

   // receiver side: ready changes at the falling edge only
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // every rsp transfer is checked against the oldest predicted result
   always @(posedge clock) begin : check_rsp
      utf8_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            note_error($sformatf("unexpected result code_point %h", rsp_code_point));
         end else begin
            want = expected_points.pop_front();
            if (rsp_code_point !== want.cp)
               note_error($sformatf("code_point got %h want %h", rsp_code_point, want.cp));
            if (rsp_char_class !== want.cls)
               note_error($sformatf("char_class got %0d want %0d", rsp_char_class, want.cls));
            if (rsp_byte_count !== want.cnt)
               note_error($sformatf("byte_count got %0d want %0d", rsp_byte_count, want.cnt));
            if (rsp_last_of_run !== want.last)
               note_error($sformatf("last_of_run got %0d want %0d", rsp_last_of_run,
                                    want.last));
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_in_byte    = 8'h00;
      req_final_byte = 1'b0;
      rsp_ready      = 1'b0;
      held_count     = 0;
      error_count    = 0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_full_rate();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();

      // let any stray result show up before the verdict
      rsp_stall_pct = 0;
      repeat (12) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/utf8d_pkg.sv
rtl/utf8d_ctrl.sv
rtl/utf8d_dp.sv
rtl/utf8_decoder_with_raw_fallback_top.sv
rtl/utf8d_check.sv
verif/utf8_decoder_with_raw_fallback_top_tb.sv
